FILE: rtl/core/tlsa_pkg.sv
// Shared types and constants for the two-level slot allocator.
// No dependencies; used by the top level and the port checker.
package tlsa_pkg;

  localparam int CLIENT_SLOTS_DEFAULT = 64;
  localparam int STREAM_SLOTS_DEFAULT = 8;

  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 16;

  typedef enum logic [1:0] {
    OP_ALLOC_CLIENT = 2'd0,
    OP_FREE_CLIENT  = 2'd1,
    OP_ALLOC_STREAM = 2'd2,
    OP_FREE_STREAM  = 2'd3
  } op_t;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_NO_SLOT = 2'd1;
  localparam logic [1:0] STATUS_BUSY    = 2'd2;

endpackage

FILE: rtl/core/two_level_slot_allocator_top.sv
// Two-level slot allocator: client free map in flops, per-client stream maps in RAM.
// Depends on tlsa_pkg and tlsa_ram.
//
//   channel | dir | handshake         | payload
//   --------+-----+-------------------+--------------------------------------------
//   request | in  | s_tvalid/s_tready | operation, client_slot, stream_slot
//   result  | out | m_tvalid/m_tready | status, granted_index, streams_in_use
//
// In each transaction the accept cycle issues the stream-map read; the busy
// state then sees the RAM data and, once the output register is free, updates
// the maps and loads the output register. One request is in flight at a time,
// so a read never meets a write to the same entry. A result waiting in the
// output register does not block the next accept; a stalled result only
// holds the update stage. Reset marks every client free and every stream map
// as all free through one valid bit per client; no clearing pass is needed.
module two_level_slot_allocator_top #(
  parameter int CLIENT_SLOTS = tlsa_pkg::CLIENT_SLOTS_DEFAULT,
  parameter int STREAM_SLOTS = tlsa_pkg::STREAM_SLOTS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // [1:0] operation, [7:2] client_slot, [10:8] stream_slot, [15:11] zero
  input  logic [tlsa_pkg::IN_DATA_W-1:0]  s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [1:0] status, [7:2] granted_index, [11:8] streams_in_use, [15:12] zero
  output logic [tlsa_pkg::OUT_DATA_W-1:0] m_tdata
);

  localparam int CW = (CLIENT_SLOTS > 1) ? $clog2(CLIENT_SLOTS) : 1;
  localparam int SW = STREAM_SLOTS;
  localparam int NW = $clog2(STREAM_SLOTS + 1);
  localparam logic [SW-1:0] ALL_FREE = {SW{1'b1}};

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_BUSY = 2'b10
  } state_t;

  state_t            state;
  tlsa_pkg::op_t     op;
  logic [5:0]        client_slot;
  logic [2:0]        stream_slot;
  logic              entry_valid;

  // Free map of clients (1 = free) and per-client flag "stream map written".
  logic [CLIENT_SLOTS-1:0] client_free;
  logic [CLIENT_SLOTS-1:0] map_valid;

  // Output register.
  logic [1:0]        status;
  logic [5:0]        granted_index;
  logic [3:0]        streams_in_use;

  logic              accept;
  logic              finish;
  logic [CW-1:0]     in_idx;
  logic [CW-1:0]     cs_idx;
  logic              cs_ok;
  logic              ss_ok;
  logic [SW-1:0]     ram_rdata;
  logic [SW-1:0]     fm;
  logic [SW-1:0]     ss_bit;
  logic              client_found;
  logic [CW-1:0]     client_pick;
  logic              stream_found;
  logic [4:0]        stream_pick;
  logic [NW-1:0]     free_count;
  logic              ram_we;
  logic [SW-1:0]     ram_wdata;
  logic [1:0]        status_next;
  logic [5:0]        granted_next;
  logic [3:0]        in_use_next;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign finish   = (state == S_BUSY) && (!m_tvalid || m_tready);
  assign in_idx   = CW'(s_tdata[7:2]);
  assign cs_idx   = CW'(client_slot);
  assign cs_ok    = 32'(client_slot) < CLIENT_SLOTS;
  assign ss_ok    = 32'(stream_slot) < STREAM_SLOTS;
  assign ss_bit   = SW'(1) << stream_slot;

  // An entry never written since its client was granted reads as all free.
  assign fm = entry_valid ? ram_rdata : ALL_FREE;

  tlsa_ram #(
    .WIDTH (SW),
    .DEPTH (CLIENT_SLOTS)
  ) u_stream_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cs_idx),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (in_idx),
    .rdata (ram_rdata)
  );

  // Lowest free client.
  always_comb begin
    client_found = 1'b0;
    client_pick  = '0;
    for (int i = CLIENT_SLOTS - 1; i >= 0; i--) begin
      if (client_free[i]) begin
        client_found = 1'b1;
        client_pick  = CW'(i);
      end
    end
  end

  // Lowest free stream and free-stream count of the addressed client.
  always_comb begin
    stream_found = 1'b0;
    stream_pick  = '0;
    free_count   = '0;
    for (int i = SW - 1; i >= 0; i--) begin
      if (fm[i]) begin
        stream_found = 1'b1;
        stream_pick  = 5'(i);
      end
      free_count = free_count + NW'(fm[i]);
    end
  end

  always_comb begin
    status_next  = tlsa_pkg::STATUS_OK;
    granted_next = '0;
    in_use_next  = '0;
    ram_we       = 1'b0;
    ram_wdata    = fm;
    case (op)
      tlsa_pkg::OP_ALLOC_CLIENT: begin
        if (client_found) begin
          granted_next = 6'(client_pick);
        end else begin
          status_next = tlsa_pkg::STATUS_NO_SLOT;
        end
      end
      tlsa_pkg::OP_FREE_CLIENT: begin
        if (cs_ok && fm != ALL_FREE) begin
          status_next = tlsa_pkg::STATUS_BUSY;
          in_use_next = 4'(NW'(STREAM_SLOTS) - free_count);
        end
      end
      tlsa_pkg::OP_ALLOC_STREAM: begin
        if (cs_ok && stream_found) begin
          granted_next = 6'(stream_pick);
          ram_we       = finish;
          ram_wdata    = fm & ~(SW'(1) << stream_pick);
        end else begin
          status_next = tlsa_pkg::STATUS_NO_SLOT;
        end
      end
      tlsa_pkg::OP_FREE_STREAM: begin
        ram_we    = finish && cs_ok && ss_ok;
        ram_wdata = fm | ss_bit;
      end
      default: begin
        status_next = tlsa_pkg::STATUS_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      m_tvalid    <= 1'b0;
      client_free <= '1;
      map_valid   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_BUSY;
          end
        end
        S_BUSY: begin
          if (finish) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      if (finish) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      if (finish) begin
        // Grant: take the client and mark its stream map as fresh.
        if (op == tlsa_pkg::OP_ALLOC_CLIENT && client_found) begin
          client_free[client_pick] <= 1'b0;
          map_valid[client_pick]   <= 1'b0;
        end
        if (op == tlsa_pkg::OP_FREE_CLIENT && cs_ok && fm == ALL_FREE) begin
          client_free[cs_idx] <= 1'b1;
        end
        if (ram_we) begin
          map_valid[cs_idx] <= 1'b1;
        end
      end
    end
  end

  // Payload registers: captured on accept and on finish, no reset needed.
  always_ff @(posedge clk) begin
    if (accept) begin
      op          <= tlsa_pkg::op_t'(s_tdata[1:0]);
      client_slot <= s_tdata[7:2];
      stream_slot <= s_tdata[10:8];
      entry_valid <= map_valid[in_idx];
    end
    if (finish) begin
      status         <= status_next;
      granted_index  <= granted_next;
      streams_in_use <= in_use_next;
    end
  end

  assign m_tdata = {4'b0000, streams_in_use, granted_index, status};

endmodule

FILE: rtl/core/tlsa_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module tlsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic                                 re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/tlsa_checker.sv
// Port-level checker for the two-level slot allocator, bound to the top level.
// Depends on tlsa_pkg and two_level_slot_allocator_top.
module tlsa_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic [tlsa_pkg::IN_DATA_W-1:0]  s_tdata,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [tlsa_pkg::OUT_DATA_W-1:0] m_tdata
);

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed or dropped");

  // Only one request in flight: drop ready after each accepted transaction.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request accepted while another is in flight");

  // A grant index appears only with status ok.
  a_index_on_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1:0] != tlsa_pkg::STATUS_OK |-> m_tdata[7:2] == 6'd0)
    else $error("grant index on a failed transaction");

  // A busy count appears only with status busy, and status is never the unused code.
  a_count_on_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1:0] != tlsa_pkg::STATUS_BUSY
      |-> m_tdata[11:8] == 4'd0 && m_tdata[1:0] != 2'd3)
    else $error("stream count without busy status");

endmodule

bind two_level_slot_allocator_top tlsa_checker u_tlsa_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

FILE: sim/two_level_slot_allocator_top_tb.sv
// Self-checking testbench for the two-level slot allocator top level.
// Depends on tlsa_pkg and two_level_slot_allocator_top; drives request transactions,
// predicts each result from a local copy of both free maps and checks it in order.
module two_level_slot_allocator_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_CLIENTS = tlsa_pkg::CLIENT_SLOTS_DEFAULT;
  localparam int NUM_STREAMS = tlsa_pkg::STREAM_SLOTS_DEFAULT;
  // Cycles without any accepted transaction before the run is declared hung.
  localparam int STALL_LIMIT = 4000;

  // One result as the block packs it, lowest field last in the declaration.
  typedef struct packed {
    logic [3:0] in_use;
    logic [5:0] index;
    logic [1:0] status;
  } grant_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  // [1:0] operation, [7:2] client_slot, [10:8] stream_slot, [15:11] zero
  logic [tlsa_pkg::IN_DATA_W-1:0]  s_tdata = '0;
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  // [1:0] status, [7:2] granted_index, [11:8] streams_in_use, [15:12] zero
  logic [tlsa_pkg::OUT_DATA_W-1:0] m_tdata;

  // Local copy of the allocator state: 1 = free.
  logic [NUM_CLIENTS-1:0] client_free_map;
  logic [NUM_STREAMS-1:0] stream_free_map [NUM_CLIENTS];

  grant_t expected_grants [$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int error_count   = 0;
  int requests_sent = 0;
  int grants_seen   = 0;
  int no_slot_seen  = 0;
  int busy_seen     = 0;

  two_level_slot_allocator_top u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  // Receiver back-pressure: redraw tready on every falling edge.
  always @(negedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Advance the local maps by one request and return the result it must produce.
  function automatic grant_t predict_grant(input tlsa_pkg::op_t op, input logic [5:0] cs,
                                           input logic [2:0] ss);
    grant_t r;
    bit     found;
    int     busy;
    r     = '0;
    found = 1'b0;
    busy  = 0;
    case (op)
      tlsa_pkg::OP_ALLOC_CLIENT: begin
        // Lowest free client wins; its stream map starts out all free.
        for (int i = 0; i < NUM_CLIENTS; i++) begin
          if (!found && client_free_map[i]) begin
            found              = 1'b1;
            client_free_map[i] = 1'b0;
            stream_free_map[i] = '1;
            r.index            = 6'(i);
          end
        end
        if (!found) r.status = tlsa_pkg::STATUS_NO_SLOT;
      end
      tlsa_pkg::OP_FREE_CLIENT: begin
        if (cs < NUM_CLIENTS) begin
          if (&stream_free_map[cs]) begin
            client_free_map[cs] = 1'b1;
          end else begin
            for (int j = 0; j < NUM_STREAMS; j++) busy += !stream_free_map[cs][j];
            r.status = tlsa_pkg::STATUS_BUSY;
            r.in_use = 4'(busy);
          end
        end
      end
      tlsa_pkg::OP_ALLOC_STREAM: begin
        if (cs < NUM_CLIENTS) begin
          for (int j = 0; j < NUM_STREAMS; j++) begin
            if (!found && stream_free_map[cs][j]) begin
              found                  = 1'b1;
              stream_free_map[cs][j] = 1'b0;
              r.index                = 6'(j);
            end
          end
        end
        if (!found) r.status = tlsa_pkg::STATUS_NO_SLOT;
      end
      default: begin
        // Free stream: giving back a free or out-of-range slot is harmless.
        if (cs < NUM_CLIENTS && ss < NUM_STREAMS) stream_free_map[cs][ss] = 1'b1;
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    error_count++;
  endtask

  // Send one request transaction; called and returning at a falling edge.
  task automatic send_request(input tlsa_pkg::op_t op, input logic [5:0] cs,
                              input logic [2:0] ss);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {5'd0, ss, cs, op};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    // Accepted at this edge: predict now, the result comes later.
    expected_grants.push_back(predict_grant(op, cs, ss));
    requests_sent++;
    @(negedge clk);
  endtask

  // Compare every accepted result with the oldest expectation.
  always @(posedge clk) begin
    grant_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_grants.size() == 0) begin
        report_mismatch($sformatf("unexpected result 0x%04h", m_tdata));
      end else begin
        want = expected_grants.pop_front();
        if (m_tdata[1:0] !== want.status)
          report_mismatch($sformatf("status got %0d want %0d", m_tdata[1:0], want.status));
        if (m_tdata[7:2] !== want.index)
          report_mismatch($sformatf("granted_index got %0d want %0d", m_tdata[7:2],
                                    want.index));
        if (m_tdata[11:8] !== want.in_use)
          report_mismatch($sformatf("streams_in_use got %0d want %0d", m_tdata[11:8],
                                    want.in_use));
        if (m_tdata[15:12] !== 4'd0)
          report_mismatch($sformatf("pad bits got 0x%0h", m_tdata[15:12]));
        grants_seen++;
        if (want.status == tlsa_pkg::STATUS_NO_SLOT) no_slot_seen++;
        if (want.status == tlsa_pkg::STATUS_BUSY) busy_seen++;
      end
    end
  end

  // Hang detector: end the run when no transaction moves for too long.
  initial begin
    int stall;
    stall = 0;
    while (stall < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall = 0;
      else stall++;
    end
    $display("no transaction for %0d cycles", STALL_LIMIT);
    $display("two_level_slot_allocator_top_tb: errors");
    $finish;
  end

  // Corner cases: unallocated clients, a full stream map, busy refusals, reuse.
  task automatic test_directed();
    // Free a client that was never granted: stays free, ok.
    send_request(tlsa_pkg::OP_FREE_CLIENT, 6'd0, 3'd0);
    // Stream ops on an unallocated client are accepted and checked like any other.
    send_request(tlsa_pkg::OP_ALLOC_STREAM, 6'd63, 3'd7);
    send_request(tlsa_pkg::OP_FREE_CLIENT, 6'd63, 3'd7);
    send_request(tlsa_pkg::OP_FREE_STREAM, 6'd63, 3'd0);
    // Give back a stream that is already free.
    send_request(tlsa_pkg::OP_FREE_STREAM, 6'd63, 3'd0);
    // Grant client 0; slot fields are don't-care for this operation.
    send_request(tlsa_pkg::OP_ALLOC_CLIENT, 6'd63, 3'd7);
    // Fill all streams of client 0, then one more gets no slot.
    for (int j = 0; j <= NUM_STREAMS; j++)
      send_request(tlsa_pkg::OP_ALLOC_STREAM, 6'd0, 3'(j));
    // Refused free with every stream busy: the widest count.
    send_request(tlsa_pkg::OP_FREE_CLIENT, 6'd0, 3'd0);
    send_request(tlsa_pkg::OP_FREE_STREAM, 6'd0, 3'd7);
    send_request(tlsa_pkg::OP_FREE_CLIENT, 6'd0, 3'd0);
    send_request(tlsa_pkg::OP_ALLOC_STREAM, 6'd0, 3'd0);
    // Grant, free and re-grant a client with no streams in use.
    send_request(tlsa_pkg::OP_ALLOC_CLIENT, 6'd0, 3'd0);
    send_request(tlsa_pkg::OP_FREE_CLIENT, 6'd1, 3'd0);
    send_request(tlsa_pkg::OP_ALLOC_CLIENT, 6'd0, 3'd0);
  endtask

  // Mostly well-formed traffic: slots are drawn from what is held right now.
  // Blocks of 100 requests alternate at random between filling and draining.
  task automatic run_random(input int count);
    int            roll;
    bit            fill_mode;
    tlsa_pkg::op_t op;
    logic[5:0]     cs;
    logic[2:0]     ss;
    int            owned [$];
    int            busy [$];
    fill_mode = 1'b1;
    for (int n = 0; n < count; n++) begin
      if (n % 100 == 0) fill_mode = $urandom_range(0, 1);
      roll = $urandom_range(0, 99);
      if (fill_mode)
        op = tlsa_pkg::op_t'((roll < 40) ? tlsa_pkg::OP_ALLOC_CLIENT :
                             (roll < 80) ? tlsa_pkg::OP_ALLOC_STREAM :
                             (roll < 92) ? tlsa_pkg::OP_FREE_STREAM :
                                           tlsa_pkg::OP_FREE_CLIENT);
      else
        op = tlsa_pkg::op_t'((roll < 10) ? tlsa_pkg::OP_ALLOC_CLIENT :
                             (roll < 20) ? tlsa_pkg::OP_ALLOC_STREAM :
                             (roll < 65) ? tlsa_pkg::OP_FREE_STREAM :
                                           tlsa_pkg::OP_FREE_CLIENT);
      cs = 6'($urandom_range(0, 63));
      ss = 3'($urandom_range(0, 7));
      owned.delete();
      for (int i = 0; i < NUM_CLIENTS; i++) if (!client_free_map[i]) owned.push_back(i);
      // Hit held clients most of the time, the rest is noise.
      if (owned.size() > 0 && $urandom_range(0, 99) < 85)
        cs = 6'(owned[$urandom_range(0, owned.size() - 1)]);
      busy.delete();
      for (int j = 0; j < NUM_STREAMS; j++) if (!stream_free_map[cs][j]) busy.push_back(j);
      if (op == tlsa_pkg::OP_FREE_STREAM && busy.size() > 0 && $urandom_range(0, 99) < 80)
        ss = 3'(busy[$urandom_range(0, busy.size() - 1)]);
      send_request(op, cs, ss);
    end
  endtask

  task automatic test_random_slow_receiver();
    send_idle_pct = 21;
    recv_idle_pct = 77;
    run_random(680);
  endtask

  task automatic test_random_slow_sender();
    send_idle_pct = 77;
    recv_idle_pct = 21;
    run_random(660);
  endtask

  task automatic test_random_full_rate();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(660);
  endtask

  initial begin
    client_free_map = '1;
    for (int i = 0; i < NUM_CLIENTS; i++) stream_free_map[i] = '1;
    send_idle_pct = 21;
    recv_idle_pct = 77;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed();
    test_random_slow_receiver();
    test_random_slow_sender();
    test_random_full_rate();
    s_tvalid <= 1'b0;

    // Drain outstanding results, then keep watching for strays.
    while (expected_grants.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("covered %0d requests under three back-pressure mixes, %0d results checked",
             requests_sent, grants_seen);
    $display("refusals seen: %0d with no free slot, %0d with streams still busy",
             no_slot_seen, busy_seen);
    if (error_count == 0) begin
      $display("two_level_slot_allocator_top_tb: clean");
    end else begin
      $display("two_level_slot_allocator_top_tb: errors");
    end
    $finish;
  end

endmodule
